@@ src/tqr_pkg.sv @@
`default_nettype none
package tqr_pkg;

	// screen and tile buffer geometry
	localparam int SCREEN_WIDTH  = 480;
	localparam int SCREEN_HEIGHT = 480;
	localparam int TILE_LINES    = 10;
	localparam int BUF_CAP       = SCREEN_WIDTH * TILE_LINES;

	// coordinates are kept to 9 bits on the window outputs
	localparam logic [8:0] SCREEN_W_LAST = 9'((SCREEN_WIDTH - 1) % 512);
	localparam logic [8:0] SCREEN_H_LAST = 9'((SCREEN_HEIGHT - 1) % 512);

	// default depth of the job queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_MOUNT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_UI    = 1'b1;

	// quarter-turn rotation codes
	localparam logic [1:0] ROT_0   = 2'd0;
	localparam logic [1:0] ROT_90  = 2'd1;
	localparam logic [1:0] ROT_180 = 2'd2;
	localparam logic [1:0] ROT_270 = 2'd3;

	typedef struct packed {
		logic [8:0]  area_left;
		logic [8:0]  area_top;
		logic [8:0]  area_right;
		logic [8:0]  area_bottom;
		logic [15:0] pixel_in;
	} tqr_in_t;

	typedef struct packed {
		logic [12:0] dest_index;
		logic [15:0] pixel_out;
		logic [8:0]  window_left;
		logic [8:0]  window_top;
		logic [8:0]  window_right;
		logic [8:0]  window_bottom;
		logic        tile_last;
		logic        oversize;
	} tqr_out_t;

	// classified pixel: index = mul_a * mul_b + addend
	typedef struct packed {
		logic [1:0]  rot;
		logic [8:0]  mul_a;
		logic [9:0]  mul_b;
		logic [8:0]  addend;
		logic [8:0]  span_w;
		logic [8:0]  span_h;
		logic [8:0]  left;
		logic [8:0]  top;
		logic [8:0]  right;
		logic [8:0]  bottom;
		logic [15:0] pixel;
		logic        last;
	} tqr_job_t;

endpackage
`default_nettype wire

@@ src/tqr_front.sv @@
`default_nettype none
module tqr_front (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 in_valid,
	output logic                                in_stall,
	input  wire  tqr_pkg::tqr_in_t              in_data,
	input  wire                                 cfg_we,
	input  wire  [tqr_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire  [tqr_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  wire                                 queue_full,
	output logic                                push,
	output tqr_pkg::tqr_job_t                   job
);

	logic [1:0] mount_q, ui_q;
	logic [8:0] col_q, row_q;
	logic [1:0] rot;
	logic [8:0] span_w, span_h;
	logic [9:0] width, height;
	logic [8:0] sx, sy;
	logic       last, wrap;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mount_q <= '0;
			ui_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				tqr_pkg::CFG_MOUNT: mount_q <= cfg_data[1:0];
				tqr_pkg::CFG_UI:    ui_q    <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// mount is applied inverted
	assign rot = ui_q - mount_q;

	// tile size and current position
	assign span_w = in_data.area_right - in_data.area_left;
	assign span_h = in_data.area_bottom - in_data.area_top;
	assign width  = {1'b0, span_w} + 10'd1;
	assign height = {1'b0, span_h} + 10'd1;

	always_comb begin
		if (({1'b0, col_q} < width) && ({1'b0, row_q} < height)) begin
			sx = col_q;
			sy = row_q;
		end else begin
			sx = '0;
			sy = '0;
		end
	end

	assign wrap = (sx == span_w);
	assign last = wrap && (sy == span_h);

	assign push     = in_valid && !queue_full;
	assign in_stall = queue_full;

	// position counters advance per accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (push) begin
			if (last) begin
				col_q <= '0;
				row_q <= '0;
			end else if (wrap) begin
				col_q <= '0;
				row_q <= sy + 9'd1;
			end else begin
				col_q <= sx + 9'd1;
				row_q <= sy;
			end
		end
	end

	// pick multiply operands for the rotation
	always_comb begin
		job.rot    = rot;
		job.span_w = span_w;
		job.span_h = span_h;
		job.left   = in_data.area_left;
		job.top    = in_data.area_top;
		job.right  = in_data.area_right;
		job.bottom = in_data.area_bottom;
		job.pixel  = in_data.pixel_in;
		job.last   = last;
		case (rot)
			tqr_pkg::ROT_90: begin
				job.mul_a  = span_w - sx;
				job.mul_b  = height;
				job.addend = sy;
			end
			tqr_pkg::ROT_180: begin
				job.mul_a  = span_h - sy;
				job.mul_b  = width;
				job.addend = span_w - sx;
			end
			tqr_pkg::ROT_270: begin
				job.mul_a  = sx;
				job.mul_b  = height;
				job.addend = span_h - sy;
			end
			default: begin
				job.mul_a  = sy;
				job.mul_b  = width;
				job.addend = sx;
			end
		endcase
	end

endmodule
`default_nettype wire

@@ src/tqr_queue.sv @@
`default_nettype none
module tqr_queue #(
	parameter int DEPTH = tqr_pkg::QUEUE_DEPTH
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      push,
	input  wire tqr_pkg::tqr_job_t   push_job,
	output logic                     full,
	input  wire                      pop,
	output logic                     head_valid,
	output tqr_pkg::tqr_job_t        head_job
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

	tqr_pkg::tqr_job_t entries_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full       = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_job   = entries_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_job;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule
`default_nettype wire

@@ src/tqr_back.sv @@
`default_nettype none
module tqr_back (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      head_valid,
	input  wire tqr_pkg::tqr_job_t   head_job,
	output logic                     pop,
	output logic                     out_valid,
	input  wire                      out_stall,
	output tqr_pkg::tqr_out_t        out_data
);

	logic              advance;
	logic              valid_s1;
	logic [18:0]       prod_s1;
	logic [8:0]        addend_s1;
	logic [15:0]       pixel_s1;
	logic              last_s1;
	logic [8:0]        wl_s1, wt_s1, wr_s1, wb_s1;
	logic [8:0]        wl, wt, wr, wb;
	logic [18:0]       idx;
	logic              over;
	logic              out_valid_q;
	tqr_pkg::tqr_out_t out_q;

	assign advance   = !out_valid_q || !out_stall;
	assign pop       = advance && head_valid;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// rotated window
	always_comb begin
		case (head_job.rot)
			tqr_pkg::ROT_90: begin
				wl = head_job.top;
				wt = tqr_pkg::SCREEN_W_LAST - head_job.right;
				wr = wl + head_job.span_h;
				wb = wt + head_job.span_w;
			end
			tqr_pkg::ROT_180: begin
				wl = tqr_pkg::SCREEN_W_LAST - head_job.right;
				wt = tqr_pkg::SCREEN_H_LAST - head_job.bottom;
				wr = wl + head_job.span_w;
				wb = wt + head_job.span_h;
			end
			tqr_pkg::ROT_270: begin
				wl = tqr_pkg::SCREEN_H_LAST - head_job.bottom;
				wt = head_job.left;
				wr = wl + head_job.span_h;
				wb = wt + head_job.span_w;
			end
			default: begin
				wl = head_job.left;
				wt = head_job.top;
				wr = head_job.right;
				wb = head_job.bottom;
			end
		endcase
	end

	// stage 1: multiply and window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= head_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			prod_s1   <= {10'd0, head_job.mul_a} * {9'd0, head_job.mul_b};
			addend_s1 <= head_job.addend;
			pixel_s1  <= head_job.pixel;
			last_s1   <= head_job.last;
			wl_s1     <= wl;
			wt_s1     <= wt;
			wr_s1     <= wr;
			wb_s1     <= wb;
		end
	end

	// stage 2: add offset, capacity check
	assign idx  = prod_s1 + {10'd0, addend_s1};
	assign over = ({13'd0, idx} >= 32'(tqr_pkg::BUF_CAP));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			out_q.dest_index    <= over ? 13'd0 : idx[12:0];
			out_q.pixel_out     <= pixel_s1;
			out_q.window_left   <= wl_s1;
			out_q.window_top    <= wt_s1;
			out_q.window_right  <= wr_s1;
			out_q.window_bottom <= wb_s1;
			out_q.tile_last     <= last_s1;
			out_q.oversize      <= over;
		end
	end

endmodule
`default_nettype wire

@@ src/tile_quadrant_rotator_core.sv @@
// path: a pixel passes through the job queue, the multiply registers and the output register
// throughput: one pixel per cycle while the output is not stalled, set by the single registered multiplier stage
// a queue of QUEUE_DEPTH entries lets the input keep accepting while output stalls, until the queue is full
// reset: asynchronous, active low; rotation registers, tile position and queue
// are cleared, no output is valid until new pixels arrive
`default_nettype none
module tile_quadrant_rotator_core #(
	parameter int QUEUE_DEPTH = tqr_pkg::QUEUE_DEPTH
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             in_valid,
	output logic                            in_stall,
	input  wire  tqr_pkg::tqr_in_t          in_data,
	output logic                            out_valid,
	input  wire                             out_stall,
	output tqr_pkg::tqr_out_t               out_data,
	input  wire                             cfg_we,
	input  wire  [tqr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire  [tqr_pkg::CFG_DATA_W-1:0]  cfg_data
);

	logic              push, full, pop, head_valid;
	tqr_pkg::tqr_job_t push_job, head_job;

	// position tracking and classification
	tqr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.queue_full (full),
		.push       (push),
		.job        (push_job)
	);

	// decoupling queue
	tqr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	// index and window computation
	tqr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data)
	);

endmodule
`default_nettype wire

@@ src/tqr_checker.sv @@
`default_nettype none
module tqr_checker (
	input wire                     clk,
	input wire                     arst_n,
	input wire                     in_stall,
	input wire                     out_valid,
	input wire                     out_stall,
	input wire tqr_pkg::tqr_out_t  out_data
);

	// stalled output transaction holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("output transaction changed while stalled");

	// nothing pending right after reset
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid && !in_stall)
		else $error("output valid or input stalled out of reset");

	// oversize pixels carry a zero index
	a_oversize_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.oversize |-> out_data.dest_index == 13'd0)
		else $error("oversize pixel with nonzero index");

	// input backs up only behind a held output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled while output is empty");

endmodule

bind tile_quadrant_rotator_core tqr_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
`default_nettype wire
